[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the clocked implication checks that the project uses.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/udr_pkg.sv]
// ----------------------------------------------------------------------------
// udr_pkg
// Types and constants shared by the divider controller and datapath.
// ----------------------------------------------------------------------------
package udr_pkg;

  localparam int unsigned DataWidthDefault = 32;

  typedef enum logic [1:0] {
    OP_QUOTIENT   = 2'd0,
    OP_REMAINDER  = 2'd1,
    OP_RECIPROCAL = 2'd2,
    OP_UNUSED     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ALIGN  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic align_step;
    logic div_step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic early_exit;
    logic align_last;
    logic div_last;
  } sts_t;

endpackage

[hw/rtl/unsigned_divider_with_reciprocal.sv]
// ----------------------------------------------------------------------------
// unsigned_divider_with_reciprocal
// Unsigned divider giving quotient, remainder or all-ones reciprocal.
// ----------------------------------------------------------------------------
// An item carries an operation code, a dividend and a divisor; the block
// returns one result item holding the quotient, the remainder, or the
// reciprocal (the all-ones word divided by the divisor), and keeps nothing
// between items. Division is restoring shift-subtract: after the item is
// taken, the divisor is aligned under the dividend in log2(DATA_WIDTH) coarse
// steps (16, 8, 4, 2 and 1 bits at the default width), then one quotient bit
// is resolved per cycle, for k+1 bit positions where k is the alignment shift,
// and the value then moves into the output register once that register is free.
// When the divisor is zero or exceeds the dividend (the all-ones word for a
// reciprocal), alignment and division are skipped: the quotient or
// reciprocal is 0 and the remainder is the dividend. Operation code 3 gives
// 0. One item is worked on at a time; the next item may be taken while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module unsigned_divider_with_reciprocal #(
  parameter int unsigned DATA_WIDTH = udr_pkg::DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] result_o
);
  import udr_pkg::*;

  // Commands run from the sequencer to the datapath, status comes back.
  cmd_t cmd;
  sts_t sts;

  udr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  udr_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (op_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .result_o   (result_o)
  );

endmodule

[hw/rtl/udr_ctrl.sv]
// ----------------------------------------------------------------------------
// udr_ctrl
// Sequencer of the divider: load, coarse alignment, one quotient bit per
// cycle, then hand-off to the output register.
// ----------------------------------------------------------------------------
module udr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  udr_pkg::sts_t sts_i,
  output udr_pkg::cmd_t cmd_o
);
  import udr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // Divisor zero or above the dividend: the loaded values are the answer.
        if (sts_i.early_exit) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.align_step = 1'b1;
          if (sts_i.align_last) begin
            state_d = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.write_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.write_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/udr_datapath.sv]
// ----------------------------------------------------------------------------
// udr_datapath
// Operand registers, coarse divisor alignment and the restoring
// shift-subtract step, plus the output result register.
// ----------------------------------------------------------------------------
module udr_datapath #(
  parameter int unsigned DATA_WIDTH = udr_pkg::DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  udr_pkg::cmd_t         cmd_i,
  output udr_pkg::sts_t         sts_o,
  input  logic [1:0]            op_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output logic [DATA_WIDTH-1:0] result_o
);
  import udr_pkg::*;

  localparam int unsigned CntW   = $clog2(DATA_WIDTH);
  localparam int unsigned Stages = CntW;
  localparam int unsigned StageW = (Stages > 1) ? $clog2(Stages) : 1;

  op_e                   op_q;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] dsh_q, dsh_d;
  logic [DATA_WIDTH-1:0] res_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [StageW-1:0]     stage_q, stage_d;

  logic [CntW-1:0]         step_amt;
  logic [2*DATA_WIDTH-1:0] dsh_wide;
  logic                    step_fits;
  logic                    sub_ok;
  logic [DATA_WIDTH-1:0]   res_sel;

  // Alignment step sizes run from half the width down to one bit.
  assign step_amt  = CntW'(1) << stage_q;
  assign dsh_wide  = {{DATA_WIDTH{1'b0}}, dsh_q} << step_amt;
  assign step_fits = (dsh_wide[2*DATA_WIDTH-1:DATA_WIDTH] == '0) &&
                     (dsh_wide[DATA_WIDTH-1:0] <= rem_q);
  assign sub_ok    = (rem_q >= dsh_q);

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsh_d   = dsh_q;
    cnt_d   = cnt_q;
    stage_d = stage_q;
    if (cmd_i.load) begin
      // The reciprocal divides the all-ones word.
      rem_d   = (op_e'(op_i) == OP_RECIPROCAL) ? {DATA_WIDTH{1'b1}} : dividend_i;
      quo_d   = '0;
      dsh_d   = divisor_i;
      cnt_d   = '0;
      stage_d = StageW'(Stages - 1);
    end else if (cmd_i.align_step) begin
      if (step_fits) begin
        dsh_d = dsh_wide[DATA_WIDTH-1:0];
        cnt_d = cnt_q + step_amt;
      end
      stage_d = stage_q - StageW'(1);
    end else if (cmd_i.div_step) begin
      if (sub_ok) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[DATA_WIDTH-2:0], sub_ok};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_comb begin
    case (op_q)
      OP_QUOTIENT:   res_sel = quo_q;
      OP_REMAINDER:  res_sel = rem_q;
      OP_RECIPROCAL: res_sel = quo_q;
      default:       res_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      cnt_q   <= '0;
    end else begin
      stage_q <= stage_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsh_q <= dsh_d;
    if (cmd_i.load) begin
      op_q <= op_e'(op_i);
    end
    if (cmd_i.write_out) begin
      res_q <= res_sel;
    end
  end

  assign sts_o.early_exit = (dsh_q == '0) || (rem_q < dsh_q);
  assign sts_o.align_last = (stage_q == '0);
  assign sts_o.div_last   = (cnt_q == '0);
  assign result_o         = res_q;

endmodule

[hw/rtl/udr_checker.sv]
// ----------------------------------------------------------------------------
// udr_checker
// Port-level checks on the divider, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udr_checker #(
  parameter int unsigned DATA_WIDTH = udr_pkg::DataWidthDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] result_o
);

  // A stalled result stays put.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o && $stable(result_o))

  // Once an item is taken the block is busy for at least the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
               !in_ready_o)

  // A new result only appears at the end of work, never out of idle.
  `ASSERT_SAME(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o),
               $past(!in_ready_o))

  // The block returns to idle in the cycle that a result is loaded.
  `ASSERT_SAME(a_idle_after_result, clk_i, rst_ni, $rose(out_valid_o), in_ready_o)

endmodule

bind unsigned_divider_with_reciprocal udr_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_udr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_o    (result_o)
);
